/* sv/ber_tag_length_header_parser_assert.svh */
// Assertion macros for the BER header parser, clocked on clk with arst_n reset.
`ifndef BER_TAG_LENGTH_HEADER_PARSER_ASSERT_SVH
`define BER_TAG_LENGTH_HEADER_PARSER_ASSERT_SVH

// Checked property, disabled while reset is asserted.
`define BTLH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked property, also active during reset.
`define BTLH_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/btlh_pkg.sv */
// Types and constants shared by the BER header parser modules.
`default_nettype none

package btlh_pkg;

	typedef enum logic [2:0] {
		PH_IDENT    = 3'd0,
		PH_EOC      = 3'd1,
		PH_HIGHTAG  = 3'd2,
		PH_LENMODE  = 3'd3,
		PH_LENBYTES = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EOC      = 3'd1,
		ST_BAD_EOC  = 3'd2,
		ST_TAG_OVF  = 3'd3,
		ST_LEN_LONG = 3'd4
	} status_t;

	localparam logic [4:0] HIGH_TAG_ID = 5'h1f;
	localparam int unsigned RES_BITS = 71;
	localparam int unsigned RES_BYTES_BITS = 72;

	typedef struct packed {
		logic        indefinite;
		logic [31:0] content_length;
		logic [31:0] tag_number;
		logic        constructed;
		logic [1:0]  id_class;
		status_t     status;
	} result_t;

endpackage

`default_nettype wire

/* sv/btlh_core.sv */
// Header parse state and per-byte decode; one byte per enabled cycle.
`default_nettype none

module btlh_core
	import btlh_pkg::*;
#(
	parameter int unsigned TAG_WIDTH        = 32,
	parameter int unsigned MAX_LENGTH_BYTES = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire logic [7:0] byte_in,
	output logic            res_valid,
	output result_t         res
);

	localparam int unsigned LW = 8 * MAX_LENGTH_BYTES;

	phase_t          phase_q, phase_d;
	logic [1:0]      class_q, class_d;
	logic            cons_q, cons_d;
	logic [TAG_WIDTH-1:0] tag_q, tag_d;
	logic [LW-1:0]   len_q, len_d;
	logic [2:0]      left_q, left_d;

	logic [TAG_WIDTH-1:0] tag_shift;
	logic [LW-1:0]   len_shift;
	logic            tag_ovf;
	logic [6:0]      len_cnt;
	logic [63:0]     tag_ext, len_ext;

	assign tag_shift = (tag_q << 7) | TAG_WIDTH'(byte_in[6:0]);
	assign len_shift = (len_q << 8) | LW'(byte_in);
	assign tag_ovf   = tag_q[TAG_WIDTH-1 -: 7] != 7'd0;
	assign len_cnt   = byte_in[6:0];
	assign tag_ext   = 64'(tag_q);
	assign len_ext   = 64'(len_shift);

	// next state
	always_comb begin
		phase_d = phase_q;
		class_d = class_q;
		cons_d  = cons_q;
		tag_d   = tag_q;
		len_d   = len_q;
		left_d  = left_q;
		case (phase_q)
			PH_EOC: begin
				phase_d = PH_IDENT;
			end
			PH_HIGHTAG: begin
				if (tag_ovf) begin
					phase_d = PH_IDENT;
				end else begin
					tag_d = tag_shift;
					if (!byte_in[7])
						phase_d = PH_LENMODE;
				end
			end
			PH_LENMODE: begin
				if (!byte_in[7] || len_cnt == 7'd0 ||
				    len_cnt > 7'(MAX_LENGTH_BYTES)) begin
					phase_d = PH_IDENT;
				end else begin
					left_d  = 3'(len_cnt - 7'd1);
					len_d   = '0;
					phase_d = PH_LENBYTES;
				end
			end
			PH_LENBYTES: begin
				len_d = len_shift;
				if (left_q == 3'd0)
					phase_d = PH_IDENT;
				else
					left_d = left_q - 3'd1;
			end
			default: begin
				class_d = byte_in[7:6];
				cons_d  = byte_in[5];
				len_d   = '0;
				left_d  = 3'd0;
				if (byte_in[4:0] == HIGH_TAG_ID) begin
					tag_d   = '0;
					phase_d = PH_HIGHTAG;
				end else begin
					tag_d   = TAG_WIDTH'(byte_in[4:0]);
					phase_d = (byte_in[4:0] == 5'd0 && byte_in[7:6] == 2'd0) ?
					          PH_EOC : PH_LENMODE;
				end
			end
		endcase
	end

	// result
	always_comb begin
		res_valid          = 1'b0;
		res.status         = ST_OK;
		res.id_class       = class_q;
		res.constructed    = cons_q;
		res.tag_number     = tag_ext[31:0];
		res.content_length = 32'd0;
		res.indefinite     = 1'b0;
		case (phase_q)
			PH_EOC: begin
				res_valid      = 1'b1;
				res.status     = (byte_in == 8'd0) ? ST_EOC : ST_BAD_EOC;
				res.id_class   = 2'd0;
				res.tag_number = 32'd0;
			end
			PH_HIGHTAG: begin
				res_valid  = tag_ovf;
				res.status = ST_TAG_OVF;
			end
			PH_LENMODE: begin
				if (!byte_in[7]) begin
					res_valid          = 1'b1;
					res.content_length = {24'd0, byte_in};
				end else if (len_cnt == 7'd0) begin
					res_valid      = 1'b1;
					res.indefinite = 1'b1;
				end else if (len_cnt > 7'(MAX_LENGTH_BYTES)) begin
					res_valid  = 1'b1;
					res.status = ST_LEN_LONG;
				end
			end
			PH_LENBYTES: begin
				res_valid          = left_q == 3'd0;
				res.content_length = len_ext[31:0];
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDENT;
			class_q <= 2'd0;
			cons_q  <= 1'b0;
			tag_q   <= '0;
			len_q   <= '0;
			left_q  <= 3'd0;
		end else if (en) begin
			phase_q <= phase_d;
			class_q <= class_d;
			cons_q  <= cons_d;
			tag_q   <= tag_d;
			len_q   <= len_d;
			left_q  <= left_d;
		end
	end

endmodule

`default_nettype wire

/* sv/ber_tag_length_header_parser.sv */
// Top level of the BER identifier-and-length header parser.
//
//  channel | dir | word                         | accepted when
//  s_*     | in  | one encoded stream byte      | s_tvalid && s_tready
//  m_*     | out | one header or error result   | m_tvalid && m_tready
//
// One byte per cycle sustained while m_tready does not stall the output; the
// byte that completes a header or raises an error passes through the input
// register, then its result is decoded into the output register.
// Reset puts the parser in the identifier phase with all fields cleared.
// A stall on m_tready holds the output register and backs up the input
// register; s_tready drops only when both are full.
`default_nettype none

module ber_tag_length_header_parser
	import btlh_pkg::*;
#(
	parameter int unsigned TAG_WIDTH        = 32,
	parameter int unsigned MAX_LENGTH_BYTES = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // data_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// status[2:0], id_class[4:3], constructed[5], tag_number[37:6],
	// content_length[69:38], indefinite[70], zero[71]
	output logic [RES_BYTES_BITS-1:0] m_tdata
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       core_en;
	logic       res_valid;
	result_t    res;
	result_t    out_q;
	logic       out_valid_q;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign core_en  = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			byte_s1 <= s_tdata;
	end

	btlh_core #(
		.TAG_WIDTH        (TAG_WIDTH),
		.MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (core_en),
		.byte_in   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= core_en && res_valid;
	end

	always_ff @(posedge clk) begin
		if (core_en && res_valid)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q};

`include "ber_tag_length_header_parser_assert.svh"

	`BTLH_ASSERT(a_stall_cause,
		!s_tready |-> (valid_s1 && out_valid_q && !m_tready),
		"input stalled without a full pipeline")
	`BTLH_ASSERT(a_status_range,
		out_valid_q |-> (out_q.status <= ST_LEN_LONG),
		"undefined status code")
	`BTLH_ASSERT(a_eoc_fields,
		(out_valid_q && (out_q.status == ST_EOC || out_q.status == ST_BAD_EOC)) |->
		(out_q.id_class == 2'd0 && out_q.tag_number == 32'd0 &&
		out_q.content_length == 32'd0 && !out_q.indefinite),
		"end of contents carries fields")
	`BTLH_ASSERT(a_indef_len,
		(out_valid_q && out_q.indefinite) |->
		(out_q.status == ST_OK && out_q.content_length == 32'd0),
		"indefinite form with a length")

endmodule

`default_nettype wire

/* tb/tb_ber_tag_length_header_parser.sv */
// Self-checking testbench for the BER identifier-and-length header parser.
`timescale 1ns / 100ps

module tb_ber_tag_length_header_parser
	import btlh_pkg::*;
();

	localparam int unsigned TAG_BITS = 32;
	localparam int unsigned LEN_BYTES_MAX = 4;
	localparam int unsigned STREAM_BYTES = 1050;

	typedef struct {
		logic [7:0] b;
		bit         typed;
		result_t    want;
	} row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [RES_BYTES_BITS-1:0] m_tdata;

	// parser state as the stream has been seen so far
	phase_t      hdr_phase = PH_IDENT;
	logic [1:0]  hdr_class = '0;
	logic        hdr_cons = 1'b0;
	logic [31:0] hdr_tag = '0;
	logic [2:0]  hdr_tag_cnt = '0;
	logic [31:0] hdr_len = '0;
	logic [2:0]  hdr_len_left = '0;

	result_t pending_headers[$];
	row_t    directed_rows[$];
	logic [7:0] burst[$];
	row_t    offer;
	int      bytes_taken = 0;
	bit      failed = 0;
	bit      held_off = 0;
	int      stall_left = 0;
	logic    quiet_stretch;

	assign quiet_stretch = (bytes_taken >= 500 && bytes_taken < 700);

	ber_tag_length_header_parser #(
		.TAG_WIDTH(TAG_BITS),
		.MAX_LENGTH_BYTES(LEN_BYTES_MAX)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// returns 1 when the byte completes a header or raises an error
	function automatic bit parse_header_byte(input logic [7:0] b, output result_t r);
		logic [6:0] count_m1;
		r = '0;
		r.status = ST_OK;
		r.id_class = hdr_class;
		r.constructed = hdr_cons;
		r.tag_number = hdr_tag;
		case (hdr_phase)
		PH_EOC: begin
			r.status = (b == 8'h00) ? ST_EOC : ST_BAD_EOC;
			r.id_class = 2'd0;
			r.tag_number = '0;
			hdr_phase = PH_IDENT;
			return 1;
		end
		PH_HIGHTAG: begin
			if (hdr_tag[31:25] != 7'd0) begin
				r.status = ST_TAG_OVF;
				hdr_phase = PH_IDENT;
				return 1;
			end
			hdr_tag = {hdr_tag[24:0], b[6:0]};
			if (hdr_tag_cnt != 3'd7)
				hdr_tag_cnt = hdr_tag_cnt + 3'd1;
			if (!b[7])
				hdr_phase = PH_LENMODE;
			return 0;
		end
		PH_LENMODE: begin
			hdr_phase = PH_IDENT;
			if (!b[7]) begin
				r.content_length = {24'd0, b};
				return 1;
			end
			if (b[6:0] == 7'd0) begin
				r.indefinite = 1'b1;
				return 1;
			end
			if (b[6:0] > LEN_BYTES_MAX) begin
				r.status = ST_LEN_LONG;
				return 1;
			end
			count_m1 = b[6:0] - 7'd1;
			hdr_len_left = count_m1[2:0];
			hdr_len = '0;
			hdr_phase = PH_LENBYTES;
			return 0;
		end
		PH_LENBYTES: begin
			hdr_len = {hdr_len[23:0], b};
			if (hdr_len_left == 3'd0) begin
				r.content_length = hdr_len;
				hdr_phase = PH_IDENT;
				return 1;
			end
			hdr_len_left = hdr_len_left - 3'd1;
			return 0;
		end
		default: begin
			hdr_class = b[7:6];
			hdr_cons = b[5];
			hdr_tag_cnt = '0;
			hdr_len = '0;
			hdr_len_left = '0;
			if (b[4:0] == HIGH_TAG_ID) begin
				hdr_tag = '0;
				hdr_phase = PH_HIGHTAG;
			end else begin
				hdr_tag = {27'd0, b[4:0]};
				hdr_phase = (b[4:0] == 5'd0 && b[7:6] == 2'd0) ? PH_EOC : PH_LENMODE;
			end
			return 0;
		end
		endcase
	endfunction

	function automatic result_t hdr(input status_t st, input logic [1:0] cls, input logic cons,
			input logic [31:0] tag, input logic [31:0] len, input logic indef);
		result_t r;
		r.status = st;
		r.id_class = cls;
		r.constructed = cons;
		r.tag_number = tag;
		r.content_length = len;
		r.indefinite = indef;
		return r;
	endfunction

	task automatic add_row(input logic [7:0] b, input bit typed, input result_t want);
		row_t t;
		t.b = b;
		t.typed = typed;
		t.want = want;
		directed_rows.insert(directed_rows.size(), t);
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			failed = 1;
		end
	endtask

	always @(posedge clk) begin : header_check
		result_t got;
		result_t want;
		result_t pred;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[RES_BITS-1:0];
				if (pending_headers.size() == 0) begin
					$display("%0t: result expected none got %h", $time, got);
					failed = 1;
				end else begin
					want = pending_headers.pop_front();
					check_field("status", 32'(want.status), 32'(got.status));
					check_field("id_class", 32'(want.id_class), 32'(got.id_class));
					check_field("constructed", 32'(want.constructed),
						32'(got.constructed));
					check_field("tag_number", want.tag_number, got.tag_number);
					check_field("content_length", want.content_length, got.content_length);
					check_field("indefinite", 32'(want.indefinite), 32'(got.indefinite));
				end
			end
			if (s_tvalid && s_tready) begin
				bytes_taken++;
				if (parse_header_byte(s_tdata, pred))
					pending_headers.insert(pending_headers.size(),
						offer.typed ? offer.want : pred);
				else if (offer.typed)
					pending_headers.insert(pending_headers.size(), offer.want);
			end
		end
	end

	// receiver: random stalls, one long hold-off, one calm stretch
	initial begin
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!held_off && bytes_taken >= 250) begin
				held_off = 1;
				stall_left = 300;
			end
			if (stall_left != 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= quiet_stretch || ($urandom_range(0, 99) >= 35);
			end
		end
	end

	task automatic send_byte(input row_t r);
		while (!quiet_stretch && $urandom_range(0, 99) < 35) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		offer = r;
		s_tvalid <= 1'b1;
		s_tdata <= r.b;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic queue_random_header();
		int kind;
		int n;
		logic [31:0] rnd;
		logic [7:0] ident;
		kind = $urandom_range(0, 99);
		ident = 8'($urandom);
		if (kind < 10) begin
			burst.insert(burst.size(), {2'b00, ident[5], 5'd0});
			rnd = $urandom;
			burst.insert(burst.size(), ($urandom_range(0, 3) == 0) ? rnd[7:0] : 8'h00);
		end else if (kind < 18) begin
			n = $urandom_range(1, 4);
			repeat (n) begin
				rnd = $urandom;
				burst.insert(burst.size(), rnd[7:0]);
			end
		end else begin
			if (kind < 26 || $urandom_range(0, 2) == 0) begin
				burst.insert(burst.size(), {ident[7:5], HIGH_TAG_ID});
				n = (kind < 26) ? $urandom_range(6, 8) : $urandom_range(1, 5);
				for (int i = 0; i < n; i++) begin
					rnd = $urandom;
					if (i == 0 && n > 1 && $urandom_range(0, 3) == 0)
						rnd[6:0] = 7'd0;
					burst.insert(burst.size(), {(i != n - 1), rnd[6:0]});
				end
			end else begin
				rnd = $urandom_range(0, 30);
				burst.insert(burst.size(), {ident[7:5], rnd[4:0]});
			end
			if (kind < 33) begin
				rnd = $urandom_range(LEN_BYTES_MAX + 1, 127);
				burst.insert(burst.size(), {1'b1, rnd[6:0]});
			end else begin
				case ($urandom_range(0, 3))
				0, 1: begin
					rnd = $urandom;
					burst.insert(burst.size(), {1'b0, rnd[6:0]});
				end
				2: burst.insert(burst.size(), 8'h80);
				default: begin
					n = $urandom_range(1, LEN_BYTES_MAX);
					rnd = n;
					burst.insert(burst.size(), {1'b1, rnd[6:0]});
					for (int i = 0; i < n; i++) begin
						rnd = $urandom;
						if (i == 0 && $urandom_range(0, 3) == 0)
							rnd[7:0] = 8'h00;
						burst.insert(burst.size(), rnd[7:0]);
					end
				end
				endcase
			end
		end
	endtask

	initial begin
		row_t r;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// end of contents with a good marker
		add_row(8'h00, 0, '0);
		add_row(8'h00, 1, hdr(ST_EOC, 2'd0, 1'b0, 32'd0, 32'd0, 1'b0));
		// constructed end marker, nonzero second byte
		add_row(8'h20, 0, '0);
		add_row(8'h55, 1, hdr(ST_BAD_EOC, 2'd0, 1'b1, 32'd0, 32'd0, 1'b0));
		// private class, largest low tag, largest short length
		add_row(8'hDE, 0, '0);
		add_row(8'h7F, 1, hdr(ST_OK, 2'd3, 1'b0, 32'd30, 32'd127, 1'b0));
		// indefinite length
		add_row(8'h61, 0, '0);
		add_row(8'h80, 1, hdr(ST_OK, 2'd1, 1'b1, 32'd1, 32'd0, 1'b1));
		// reserved length count byte
		add_row(8'h02, 0, '0);
		add_row(8'hFF, 1, hdr(ST_LEN_LONG, 2'd0, 1'b0, 32'd2, 32'd0, 1'b0));
		// high tag filling all 32 bits, then one digit too many
		add_row(8'hBF, 0, '0);
		add_row(8'h8F, 0, '0);
		add_row(8'hFF, 0, '0);
		add_row(8'hFF, 0, '0);
		add_row(8'hFF, 0, '0);
		add_row(8'hFF, 0, '0);
		add_row(8'h00, 1, hdr(ST_TAG_OVF, 2'd2, 1'b1, 32'hFFFFFFFF, 32'd0, 1'b0));
		// leading zero tag digit, longest long-form length
		add_row(8'h5F, 0, '0);
		add_row(8'h80, 0, '0);
		add_row(8'h05, 0, '0);
		add_row(8'h84, 0, '0);
		add_row(8'hFF, 0, '0);
		add_row(8'hFF, 0, '0);
		add_row(8'hFF, 0, '0);
		add_row(8'hFF, 1, hdr(ST_OK, 2'd1, 1'b0, 32'd5, 32'hFFFFFFFF, 1'b0));

		foreach (directed_rows[i])
			send_byte(directed_rows[i]);

		r.typed = 0;
		r.want = '0;
		while (bytes_taken < STREAM_BYTES) begin
			queue_random_header();
			while (burst.size() != 0) begin
				r.b = burst.pop_front();
				send_byte(r);
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		while (pending_headers.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (failed)
			$display("== FAIL ==");
		else
			$display("== PASS ==");
		$finish;
	end

endmodule

/* sim.f */
+incdir+sv
sv/btlh_pkg.sv
sv/btlh_core.sv
sv/ber_tag_length_header_parser.sv
tb/tb_ber_tag_length_header_parser.sv
